// ----- hdl/ets_pkg.sv -----
// ets_pkg: types and constants shared by the expression token scanner.
// No dependencies; ets_front, ets_queue, ets_back and the top import it.
package ets_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned VALUE_W = 64;

  // Depth of the token-pair queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_NUM   = 2'd1,
    MODE_IDENT = 2'd2
  } scan_mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NUMBER = 4'd0,
    KIND_IDENT  = 4'd1,
    KIND_PLUS   = 4'd2,
    KIND_MINUS  = 4'd3,
    KIND_STAR   = 4'd4,
    KIND_SLASH  = 4'd5,
    KIND_LPAREN = 4'd6,
    KIND_RPAREN = 4'd7,
    KIND_END    = 4'd8,
    KIND_ERROR  = 4'd9
  } token_kind_e;

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
  } char_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]         token_kind;
    logic [FIELD_W-1:0]        token_start;
    logic [FIELD_W-1:0]        token_length;
    logic signed [VALUE_W-1:0] token_value;
    logic                      last_of_run;
  } token_item_t;

  typedef struct packed {
    token_kind_e        kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] length;
    logic [VALUE_W-1:0] value;
  } tok_rec_t;

  // All tokens caused by one character: one or two
  typedef struct packed {
    logic     two;
    tok_rec_t first;
    tok_rec_t second;
  } tok_pair_t;

endpackage

// ----- hdl/ets_stream_if.sv -----
// ets_stream_if: valid/ready channel with a typed payload.
// Standalone; payload type is set by whoever instantiates it.
interface ets_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/ets_front.sv -----
// ets_front: accepts characters, keeps the scan state, forms token pairs.
// Depends on ets_pkg and ets_stream_if.
module ets_front import ets_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ets_stream_if.sink       char_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output tok_pair_t        q_data_o
);

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned PW = (PB > FIELD_W) ? PB : FIELD_W;

  scan_mode_e         mode_q, mode_d;
  logic [PB-1:0]      pos_q, pos_d;
  logic [PB-1:0]      begin_q, begin_d;
  logic [VALUE_W-1:0] acc_q, acc_d;

  logic [CHAR_W-1:0]  c;
  logic               accept;
  logic               is_dig, is_idst, is_sep;
  logic [VALUE_W-1:0] digit;
  logic [PB-1:0]      run_len;
  logic [PW-1:0]      pos_ext, len_ext;
  logic               flush_v, own_v;
  tok_rec_t           flush_r, own_r;

  assign c       = char_i.payload.char_byte;
  assign accept  = char_i.valid & char_i.ready;
  assign char_i.ready = ~q_full_i;

  assign is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_idst = ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
                   ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_UNDER);
  assign is_sep  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  assign digit   = {{(VALUE_W-4){1'b0}}, c[3:0]};

  assign run_len = pos_q - begin_q;
  assign pos_ext = PW'(pos_q);
  assign len_ext = PW'(run_len);

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    begin_d = begin_q;
    acc_d   = acc_q;
    flush_v = 1'b0;
    own_v   = 1'b0;
    flush_r = '{kind: KIND_NUMBER, start: FIELD_W'(PW'(begin_q)), length: len_ext[FIELD_W-1:0],
                value: '0};
    own_r   = '{kind: KIND_ERROR, start: pos_ext[FIELD_W-1:0], length: FIELD_W'(1),
                value: '0};

    // saturating position count
    if (pos_q != '1) begin
      pos_d = pos_q + PB'(1);
    end

    if ((mode_q == MODE_NUM) && is_dig) begin
      acc_d = (acc_q << 3) + (acc_q << 1) + digit;
    end else if ((mode_q == MODE_IDENT) && (is_idst || is_dig)) begin
      acc_d = acc_q;
    end else begin
      unique case (mode_q)
        MODE_NUM: begin
          flush_v       = 1'b1;
          flush_r.kind  = KIND_NUMBER;
          flush_r.value = acc_q;
        end
        MODE_IDENT: begin
          flush_v      = 1'b1;
          flush_r.kind = KIND_IDENT;
        end
        default: flush_v = 1'b0;
      endcase
      mode_d = MODE_IDLE;
      acc_d  = '0;

      priority if (c == CH_NUL) begin
        own_v        = 1'b1;
        own_r.kind   = KIND_END;
        own_r.length = '0;
        pos_d        = '0;
        begin_d      = '0;
      end else if (is_sep) begin
        own_v = 1'b0;
      end else if (is_dig) begin
        mode_d  = MODE_NUM;
        begin_d = pos_q;
        acc_d   = digit;
      end else if (is_idst) begin
        mode_d  = MODE_IDENT;
        begin_d = pos_q;
      end else begin
        own_v = 1'b1;
        unique case (c)
          CH_PLUS:   own_r.kind = KIND_PLUS;
          CH_MINUS:  own_r.kind = KIND_MINUS;
          CH_STAR:   own_r.kind = KIND_STAR;
          CH_SLASH:  own_r.kind = KIND_SLASH;
          CH_LPAREN: own_r.kind = KIND_LPAREN;
          CH_RPAREN: own_r.kind = KIND_RPAREN;
          default:   own_r.kind = KIND_ERROR;
        endcase
      end
    end
  end

  // pack: flushed run first, then the character's own token
  always_comb begin
    q_data_o.two    = flush_v & own_v;
    q_data_o.first  = flush_v ? flush_r : own_r;
    q_data_o.second = own_r;
  end

  assign q_push_o = accept & (flush_v | own_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      begin_q <= '0;
      acc_q   <= '0;
    end else if (accept) begin
      pos_q   <= pos_d;
      begin_q <= begin_d;
      acc_q   <= acc_d;
    end
  end

endmodule

// ----- hdl/ets_queue.sv -----
// ets_queue: small flop FIFO of token pairs between front and back.
// Depends on ets_pkg.
module ets_queue import ets_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tok_pair_t data_i,
  input  logic      pop_i,
  output logic      valid_o,
  output logic      full_o,
  output tok_pair_t data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  tok_pair_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/ets_back.sv -----
// ets_back: serializes token pairs into single tokens in an output register.
// Depends on ets_pkg and ets_stream_if.
module ets_back import ets_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  tok_pair_t    q_data_i,
  output logic         q_pop_o,
  ets_stream_if.source token_o
);

  logic        out_valid_q, out_valid_d;
  token_item_t out_q, out_d;
  logic        sel_q, sel_d;
  logic        load;
  tok_rec_t    rec;
  logic        last;

  assign load = ~out_valid_q | token_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    sel_d       = sel_q;
    q_pop_o     = 1'b0;
    rec         = sel_q ? q_data_i.second : q_data_i.first;
    last        = sel_q | ~q_data_i.two;
    if (load) begin
      out_valid_d = q_valid_i;
      if (q_valid_i) begin
        out_d.token_kind   = rec.kind;
        out_d.token_start  = rec.start;
        out_d.token_length = rec.length;
        out_d.token_value  = rec.value;
        out_d.last_of_run  = last;
        if (last) begin
          sel_d   = 1'b0;
          q_pop_o = 1'b1;
        end else begin
          sel_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign token_o.valid   = out_valid_q;
  assign token_o.payload = out_q;

endmodule

// ----- hdl/expression_token_scanner_top.sv -----
// expression_token_scanner_top: arithmetic expression lexer, one char per transfer.
// Depends on ets_pkg, ets_stream_if, ets_front, ets_queue, ets_back.
//
//   Channel   Dir  Payload                                    Transfer when
//   char_i    in   char_byte (8)                              valid & ready
//   token_o   out  kind(4) start(16) length(16) value(64s)    valid & ready
//                  last_of_run(1)
//
// Throughput: one character per clock while the pair queue is not full. A
//   character that yields two tokens (a flushed run plus its own token) sends
//   them through the single output register one after the other, so the
//   sustained rate is one token per clock at the output while token_o is ready.
// Path: a character's tokens go into the pair queue, then to the output register.
// Reset: asynchronous, active low; scan state idle, position zero, queue
//   and output register empty.
// Stalls: the front stalls only when the two-entry pair queue is full; the
//   output register takes a new token whenever it is empty or being drained.
module expression_token_scanner_top import ets_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ets_stream_if.sink   char_i,
  ets_stream_if.source token_o
);

  // Front/back queue handshake
  logic      q_push, q_pop, q_full, q_valid;
  tok_pair_t q_wdata, q_rdata;

  // Front: classifies each character, tracks runs, position and number value
  ets_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  // Decoupling queue: lets the scanner run while the output side is stalled
  ets_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .data_o  (q_rdata)
  );

  // Back: splits pairs into single token transfers, marks the last one
  ets_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .token_o   (token_o)
  );

endmodule
